// File: src/rrtl_pkg.sv
// shared types, constants and command/status structs for the traffic light controller
// no dependencies; used by the sequencer, datapath and top level by scoped names
`default_nettype none

package rrtl_pkg;

    localparam int MAX_LIGHTS = 8;
    localparam int IDX_W      = $clog2(MAX_LIGHTS);
    localparam int TIMER_W    = 4;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int COLOR_W    = 2;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [TIMER_W-1:0] t_timer;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [CFG_W-1:0]   t_cfg;

    localparam t_color COL_RED    = 2'd0;
    localparam t_color COL_YELLOW = 2'd1;
    localparam t_color COL_GREEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 2'd3;

    localparam t_timer RESET_TIMER = 4'd5;
    localparam t_cfg   ACTIVE_RST  = 4'd2;
    localparam t_cfg   GREEN_RST   = 4'd5;
    localparam t_cfg   YELLOW_RST  = 4'd2;
    localparam t_cfg   RED_RST     = 4'd5;
    localparam t_cfg   MIN_RING    = 4'd2;

    // commands from the sequencer to the light datapath
    typedef struct packed {
        logic dec;
        logic first_green;
        logic scan;
        logic all_red;
        logic emit;
        t_idx idx;
    } t_cmd;

    // status back to the sequencer
    typedef struct packed {
        t_idx last_idx;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: src/rrtl_datapath.sv
// light state, configuration registers and the report output register
// depends on rrtl_pkg; driven by commands from rrtl_ctrl
`default_nettype none

module rrtl_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrtl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire rrtl_pkg::t_cfg                 i_cfg_data,
    input  wire rrtl_pkg::t_cmd                 i_cmd,
    output rrtl_pkg::t_status                   o_status,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output rrtl_pkg::t_idx                      o_light_index,
    output rrtl_pkg::t_color                    o_color,
    output rrtl_pkg::t_timer                    o_remaining,
    output logic                                o_last_light
);

    rrtl_pkg::t_cfg   r_active, r_green, r_yellow, r_red;
    rrtl_pkg::t_color r_color [rrtl_pkg::MAX_LIGHTS];
    rrtl_pkg::t_timer r_timer [rrtl_pkg::MAX_LIGHTS];
    rrtl_pkg::t_color n_color [rrtl_pkg::MAX_LIGHTS];
    rrtl_pkg::t_timer n_timer [rrtl_pkg::MAX_LIGHTS];

    logic             r_out_valid;
    rrtl_pkg::t_idx   r_out_index;
    rrtl_pkg::t_color r_out_color;
    rrtl_pkg::t_timer r_out_timer;
    logic             r_out_last;

    rrtl_pkg::t_cfg w_ring;
    rrtl_pkg::t_idx w_last_idx;
    rrtl_pkg::t_idx w_next_idx;
    logic           w_found;
    logic           w_all_red;

    // clamp the ring size to the supported range
    always_comb begin
        if (r_active < rrtl_pkg::MIN_RING) begin
            w_ring = rrtl_pkg::MIN_RING;
        end else if (r_active > rrtl_pkg::t_cfg'(rrtl_pkg::MAX_LIGHTS)) begin
            w_ring = rrtl_pkg::t_cfg'(rrtl_pkg::MAX_LIGHTS);
        end else begin
            w_ring = r_active;
        end
    end

    assign w_last_idx = rrtl_pkg::IDX_W'(w_ring - rrtl_pkg::t_cfg'(1));
    assign w_next_idx = (i_cmd.idx == w_last_idx) ? '0 : i_cmd.idx + rrtl_pkg::t_idx'(1);

    always_comb begin
        n_color   = r_color;
        n_timer   = r_timer;
        w_found   = 1'b0;
        w_all_red = 1'b1;
        if (i_cmd.dec) begin
            for (int i = 0; i < rrtl_pkg::MAX_LIGHTS; i++) begin
                if (rrtl_pkg::t_idx'(i) <= w_last_idx && r_timer[i] != '0) begin
                    n_timer[i] = r_timer[i] - rrtl_pkg::t_timer'(1);
                end
            end
        end
        if (i_cmd.first_green) begin
            // only the lowest green light is examined
            for (int i = 0; i < rrtl_pkg::MAX_LIGHTS; i++) begin
                if (!w_found && rrtl_pkg::t_idx'(i) <= w_last_idx
                        && r_color[i] == rrtl_pkg::COL_GREEN) begin
                    w_found = 1'b1;
                    if (r_timer[i] == '0) begin
                        n_color[i] = rrtl_pkg::COL_YELLOW;
                        n_timer[i] = r_yellow;
                    end
                end
            end
        end
        if (i_cmd.scan) begin
            if (r_color[i_cmd.idx] == rrtl_pkg::COL_YELLOW && r_timer[i_cmd.idx] == '0) begin
                n_color[i_cmd.idx]  = rrtl_pkg::COL_RED;
                n_timer[i_cmd.idx]  = r_red;
                n_color[w_next_idx] = rrtl_pkg::COL_GREEN;
                n_timer[w_next_idx] = r_green;
            end
        end
        if (i_cmd.all_red) begin
            for (int i = 0; i < rrtl_pkg::MAX_LIGHTS; i++) begin
                if (rrtl_pkg::t_idx'(i) <= w_last_idx && r_color[i] != rrtl_pkg::COL_RED) begin
                    w_all_red = 1'b0;
                end
            end
            if (w_all_red) begin
                n_color[0] = rrtl_pkg::COL_GREEN;
                n_timer[0] = r_green;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= rrtl_pkg::ACTIVE_RST;
            r_green  <= rrtl_pkg::GREEN_RST;
            r_yellow <= rrtl_pkg::YELLOW_RST;
            r_red    <= rrtl_pkg::RED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rrtl_pkg::REG_ACTIVE: r_active <= i_cfg_data;
                rrtl_pkg::REG_GREEN:  r_green  <= i_cfg_data;
                rrtl_pkg::REG_YELLOW: r_yellow <= i_cfg_data;
                rrtl_pkg::REG_RED:    r_red    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrtl_pkg::MAX_LIGHTS; i++) begin
                r_color[i] <= (i == 0) ? rrtl_pkg::COL_GREEN : rrtl_pkg::COL_RED;
                r_timer[i] <= rrtl_pkg::RESET_TIMER;
            end
        end else begin
            r_color <= n_color;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_index <= i_cmd.idx;
            r_out_color <= r_color[i_cmd.idx];
            r_out_timer <= r_timer[i_cmd.idx];
            r_out_last  <= (i_cmd.idx == w_last_idx);
        end
    end

    assign o_status.last_idx = w_last_idx;
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_light_index = r_out_index;
    assign o_color       = r_out_color;
    assign o_remaining   = r_out_timer;
    assign o_last_light  = r_out_last;

endmodule

`default_nettype wire

// File: src/rrtl_ctrl.sv
// sequencer: tick phases, one-light-per-cycle scan and report walk
// depends on rrtl_pkg; commands rrtl_datapath
`default_nettype none

module rrtl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_advance,
    output logic                   o_stall,
    output rrtl_pkg::t_cmd         o_cmd,
    input  wire rrtl_pkg::t_status i_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_GRN  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_ALLR = 3'd4;
    localparam logic [2:0] S_RPT  = 3'd5;

    logic [2:0]     r_state, n_state;
    rrtl_pkg::t_idx r_idx, n_idx;
    logic           w_last;

    assign w_last = (r_idx == i_status.last_idx);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx   = '0;
                    n_state = i_advance ? S_DEC : S_RPT;
                end
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_GRN;
            end
            S_GRN: begin
                o_cmd.first_green = 1'b1;
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (w_last) begin
                    n_state = S_ALLR;
                end else begin
                    n_idx = r_idx + rrtl_pkg::t_idx'(1);
                end
            end
            S_ALLR: begin
                o_cmd.all_red = 1'b1;
                n_idx   = '0;
                n_state = S_RPT;
            end
            S_RPT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + rrtl_pkg::t_idx'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: src/round_robin_traffic_light_controller_top.sv
// top level of the round-robin traffic light controller
// depends on rrtl_pkg, rrtl_ctrl and rrtl_datapath
`default_nettype none

// usage
// - input channel: i_valid / o_stall carry one request with i_advance; a transfer happens
//   when i_valid is high and o_stall low. advance=1 ticks the ring once then reports,
//   advance=0 only reports
// - output channel: o_valid / i_stall carry one report per active light, in index order,
//   with o_last_light set on the highest active light
// - config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 active lights, 1 green ticks, 2 yellow ticks, 3 red ticks); write only while idle
// - sequence: with n active lights, a report-only request goes straight to the report walk,
//   which loads one report at a time into the output register; a tick runs a decrement step, a
//   first-green step, n scan steps (one light per cycle through the sequencer) and an
//   all-red check before the n reports
// - the report walk is paced by the single output register: a stalled report holds and
//   the walk waits; the next request is taken once the last report is loaded
// - reset: light 0 green, all others red, every timer 5, registers to their defaults
module round_robin_traffic_light_controller_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_advance,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [2:0]                          o_light_index,
    output logic [1:0]                          o_color,
    output logic [3:0]                          o_remaining,
    output logic                                o_last_light,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrtl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rrtl_pkg::CFG_W-1:0]     i_cfg_data
);

    // command and status between sequencer and datapath
    rrtl_pkg::t_cmd    w_cmd;
    rrtl_pkg::t_status w_status;

    rrtl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_advance (i_advance),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    rrtl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_light_index (o_light_index),
        .o_color       (o_color),
        .o_remaining   (o_remaining),
        .o_last_light  (o_last_light)
    );

endmodule

`default_nettype wire

// File: src/rrtl_checker.sv
// port-level checks for the traffic light controller, bound to the top level
// depends on round_robin_traffic_light_controller_top ports only
`default_nettype none

module rrtl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_light_index,
    input wire logic [1:0] o_color,
    input wire logic       o_last_light
);

    // a stalled report holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_light_index) && $stable(o_color))
        else $error("stalled report changed");

    // a request transfer starts work, so the next one is held off
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a transfer");

    // color code 3 never appears
    a_color_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_color != 2'd3)
        else $error("illegal color reported");

    // the ring has at least two lights, and light 7, when reported, is always the last
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_light ? o_light_index != 3'd0 : o_light_index != 3'd7))
        else $error("last-light flag inconsistent with index");

endmodule

bind round_robin_traffic_light_controller_top rrtl_checker u_rrtl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_light_index (o_light_index),
    .o_color       (o_color),
    .o_last_light  (o_last_light)
);

`default_nettype wire
